// ===== hdl/apbu_pkg.sv =====
`default_nettype none

package apbu_pkg;

    // Mode codes carried in s_axis_tuser.
    localparam logic [3:0] K_SRC_ALPHA = 4'd0;
    localparam logic [3:0] K_BLEND     = 4'd1;
    localparam logic [3:0] K_INTERP    = 4'd2;
    localparam logic [3:0] K_DARKEN    = 4'd3;
    localparam logic [3:0] K_FADE      = 4'd4;
    localparam logic [3:0] K_PREMULT   = 4'd5;
    localparam logic [3:0] K_SCREEN    = 4'd6;
    localparam logic [3:0] K_DESAT     = 4'd7;
    localparam logic [3:0] K_PCT       = 4'd8;

    // Per-channel operation carried down the lane pipeline.
    typedef logic [2:0] t_lane_op;

    localparam t_lane_op OP_BASE   = 3'd0;
    localparam t_lane_op OP_SUM    = 3'd1;
    localparam t_lane_op OP_SCALE  = 3'd2;
    localparam t_lane_op OP_SCREEN = 3'd3;
    localparam t_lane_op OP_PCT    = 3'd4;

    // Reciprocal of 100 as 5243 / 2^19, exact for the truncated quotient
    // of any product of a channel difference and a percent below 100.
    localparam int          RecipShift = 19;
    localparam logic [12:0] RECIP_100  = 13'd5243;

    typedef struct packed {
        t_lane_op    op;
        logic [7:0]  mx;
        logic [7:0]  my;
        logic [7:0]  nx;
        logic [7:0]  ny;
        logic        neg;
        logic [7:0]  base;
    } t_lane_in;

endpackage

`default_nettype wire

// ===== hdl/argb_pixel_blend_unit.sv =====
// Per-pixel blend unit for 32-bit ARGB pixels, alpha in the top byte.
// Input channel (s_axis): one beat carries a mode in tuser and two pixels
// plus an 8-bit amount in tdata. Output channel (m_axis): one beat with the
// blended pixel for every input beat, in order.
// Modes: blend by source alpha, blend by amount, interpolate with alpha,
// darken, fade to transparent, premultiply, screen, desaturate and percent
// fade; unused mode codes give a zero pixel.
// Each channel lane has four register stages: operand select, multiply,
// divide-by-255 rounding (and the reciprocal multiply for the percent
// fade), then the final add, saturate and select.
// Throughput is one beat per cycle while the receiver takes beats.
// When the receiver stalls with a beat waiting, the whole pipeline holds
// and s_axis_tready drops in the same cycle; nothing is lost or repeated.
// Reset clears the stage valid bits only, so no beat is presented until
// new input arrives. s_axis_tready is held low while reset is asserted.
`default_nettype none

module argb_pixel_blend_unit (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [71:0] s_axis_tdata,  // first_pixel[31:0], second_pixel[63:32], amount[71:64]
    input  wire  [3:0]  s_axis_tuser,  // kind[3:0]
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata   // result_pixel[31:0]
);
    import apbu_pkg::*;

    localparam logic [7:0] PCT_FULL = 8'd100;
    localparam int         Stages   = 4;

    logic [Stages-1:0] r_valid;
    logic              en;

    logic [31:0] d_pix;
    logic [31:0] s_pix;
    logic [7:0]  amount;
    logic [7:0]  mx_rgb;
    logic [7:0]  mn_rgb;
    logic [8:0]  gray_sum;
    logic [7:0]  gray;

    t_lane_in    lane_in [4];
    logic [7:0]  lane_out [4];

    assign d_pix  = s_axis_tdata[31:0];
    assign s_pix  = s_axis_tdata[63:32];
    assign amount = s_axis_tdata[71:64];

    // The whole pipeline advances unless a finished beat is held by the receiver.
    assign en            = !r_valid[Stages-1] || m_axis_tready;
    assign s_axis_tready = en && i_rst_n;
    assign m_axis_tvalid = r_valid[Stages-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (en) begin
            r_valid <= {r_valid[Stages-2:0], s_axis_tvalid};
        end
    end

    always_comb begin
        mx_rgb = d_pix[23:16];
        mn_rgb = d_pix[23:16];
        if (d_pix[15:8] > mx_rgb) mx_rgb = d_pix[15:8];
        if (d_pix[7:0]  > mx_rgb) mx_rgb = d_pix[7:0];
        if (d_pix[15:8] < mn_rgb) mn_rgb = d_pix[15:8];
        if (d_pix[7:0]  < mn_rgb) mn_rgb = d_pix[7:0];
        gray_sum = {1'b0, mx_rgb} + {1'b0, mn_rgb};
        gray     = gray_sum[8:1];
    end

    always_comb begin
        logic [7:0] dc;
        logic [7:0] sc;
        logic [7:0] wt;
        for (int c = 0; c < 4; c++) begin
            dc = d_pix[8*c +: 8];
            sc = s_pix[8*c +: 8];
            wt = (s_axis_tuser == K_SRC_ALPHA) ? s_pix[31:24] : amount;
            lane_in[c] = '0;
            case (s_axis_tuser)
                K_SRC_ALPHA, K_BLEND, K_INTERP: begin
                    if (c == 3 && s_axis_tuser != K_INTERP) begin
                        lane_in[c].base = 8'hff;
                    end else begin
                        lane_in[c].op = OP_SUM;
                        lane_in[c].mx = dc;
                        lane_in[c].my = ~wt;
                        lane_in[c].nx = sc;
                        lane_in[c].ny = wt;
                    end
                end
                K_DARKEN, K_FADE, K_PREMULT: begin
                    if (c == 3 && s_axis_tuser == K_DARKEN) begin
                        lane_in[c].base = 8'hff;
                    end else if (c == 3 && s_axis_tuser == K_PREMULT) begin
                        lane_in[c].base = amount;
                    end else begin
                        lane_in[c].op = OP_SCALE;
                        lane_in[c].mx = dc;
                        lane_in[c].my = amount;
                    end
                end
                K_SCREEN: begin
                    if (c == 3) begin
                        lane_in[c].base = 8'hff;
                    end else begin
                        lane_in[c].op = OP_SCREEN;
                        lane_in[c].mx = ~dc;
                        lane_in[c].my = ~sc;
                    end
                end
                K_DESAT: begin
                    lane_in[c].base = (c == 3) ? dc : gray;
                end
                K_PCT: begin
                    if (amount == 8'd0) begin
                        lane_in[c].base = dc;
                    end else if (amount >= PCT_FULL) begin
                        lane_in[c].base = sc;
                    end else if (c == 3) begin
                        lane_in[c].base = 8'hff;
                    end else begin
                        lane_in[c].op   = OP_PCT;
                        lane_in[c].mx   = (sc >= dc) ? (sc - dc) : (dc - sc);
                        lane_in[c].my   = amount;
                        lane_in[c].neg  = (sc < dc);
                        lane_in[c].base = dc;
                    end
                end
                default: begin
                    lane_in[c].base = 8'h00;
                end
            endcase
        end
    end

    for (genvar g = 0; g < 4; g++) begin : g_lane
        apbu_lane u_lane (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_lane (lane_in[g]),
            .o_chan (lane_out[g])
        );
        assign m_axis_tdata[8*g +: 8] = lane_out[g];
    end

`ifndef SYNTH
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && en |=> r_valid[0] == $past(s_axis_tvalid))
        else $error("first stage valid does not follow the accepted beat");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && !en |=> $stable(r_valid))
        else $error("pipeline valid bits moved during a stall");

    a_reach: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && en && r_valid[Stages-2] |=> m_axis_tvalid)
        else $error("beat in the last work stage did not reach the output");

    a_stall_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while the output beat is held");
`endif

endmodule

`default_nettype wire

// ===== hdl/apbu_lane.sv =====
`default_nettype none

module apbu_lane (
    input  wire              i_clk,
    input  wire              i_en,
    input  wire apbu_pkg::t_lane_in i_lane,
    output logic [7:0]       o_chan
);
    import apbu_pkg::*;

    // round(p / 255) for p = x * a with x, a in 0..255.
    function automatic logic [7:0] round_div255(input logic [15:0] p);
        logic [16:0] t;
        logic [16:0] u;
        begin
            t = {1'b0, p} + 17'd128;
            u = t + (t >> 8);
            return u[15:8];
        end
    endfunction

    // Stage 1: operands.
    t_lane_in     r1_in;

    // Stage 2: products.
    logic [15:0]  r2_pa;
    logic [15:0]  r2_pb;
    t_lane_op     r2_op;
    logic         r2_neg;
    logic [7:0]   r2_base;

    // Stage 3: rounded quotients and the percent reciprocal product.
    logic [7:0]   r3_sa;
    logic [7:0]   r3_sb;
    logic [28:0]  r3_pq;
    t_lane_op     r3_op;
    logic         r3_neg;
    logic [7:0]   r3_base;

    logic [7:0]   n_chan;
    logic [8:0]   sum;
    logic [7:0]   pct_q;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_in   <= i_lane;

            r2_pa   <= {8'd0, r1_in.mx} * {8'd0, r1_in.my};
            r2_pb   <= {8'd0, r1_in.nx} * {8'd0, r1_in.ny};
            r2_op   <= r1_in.op;
            r2_neg  <= r1_in.neg;
            r2_base <= r1_in.base;

            r3_sa   <= round_div255(r2_pa);
            r3_sb   <= round_div255(r2_pb);
            r3_pq   <= {13'd0, r2_pa} * {16'd0, RECIP_100};
            r3_op   <= r2_op;
            r3_neg  <= r2_neg;
            r3_base <= r2_base;

            o_chan  <= n_chan;
        end
    end

    assign sum   = {1'b0, r3_sa} + {1'b0, r3_sb};
    assign pct_q = r3_pq[RecipShift+7:RecipShift];

    always_comb begin
        case (r3_op)
            OP_SUM:    n_chan = sum[8] ? 8'hff : sum[7:0];
            OP_SCALE:  n_chan = r3_sa;
            OP_SCREEN: n_chan = 8'hff - r3_sa;
            OP_PCT:    n_chan = r3_neg ? (r3_base - pct_q) : (r3_base + pct_q);
            default:   n_chan = r3_base;
        endcase
    end

endmodule

`default_nettype wire

// ===== bench/argb_pixel_blend_unit_test.sv =====
`timescale 1ns / 100ps

module argb_pixel_blend_unit_test;

    import apbu_pkg::*;

    typedef enum logic [3:0] {
        MODE_SRC_ALPHA = K_SRC_ALPHA,
        MODE_BLEND     = K_BLEND,
        MODE_INTERP    = K_INTERP,
        MODE_DARKEN    = K_DARKEN,
        MODE_FADE      = K_FADE,
        MODE_PREMULT   = K_PREMULT,
        MODE_SCREEN    = K_SCREEN,
        MODE_DESAT     = K_DESAT,
        MODE_PCT_FADE  = K_PCT,
        MODE_UNUSED_LO = 4'd9,
        MODE_UNUSED_HI = 4'd15
    } t_blend_mode;

    localparam int HoldCycles   = 64;
    localparam int StallLimit   = 1000;
    localparam int DrainCycles  = 12;
    localparam int MaxReported  = 10;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata  = '0;  // first_pixel[31:0], second_pixel[63:32], amount[71:64]
    logic [3:0]  s_axis_tuser  = '0;  // kind[3:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;        // result_pixel[31:0]

    logic [31:0] expected_pixels[$];
    int          fail_count      = 0;
    int          stall_cycles    = 0;
    bit          tx_idle_enable  = 1'b1;
    bit          rx_idle_enable  = 1'b1;
    int          hold_requests   = 0;
    int          hold_served     = 0;
    int          hold_left       = 0;

    argb_pixel_blend_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Rounded x*a/255; the quotient never lands exactly half-way.
    function automatic logic [7:0] scale_chan(input logic [7:0] x, input logic [7:0] a);
        int unsigned p;
        p = (2 * x * a + 255) / 510;
        return p[7:0];
    endfunction

    function automatic logic [7:0] mix_chan(input logic [7:0] d, input logic [7:0] s,
                                            input logic [7:0] a);
        int unsigned v;
        logic [7:0]  inv;
        inv = 8'd255 - a;
        v = scale_chan(d, inv) + scale_chan(s, a);
        return (v > 255) ? 8'hff : v[7:0];
    endfunction

    function automatic logic [7:0] screen_chan(input logic [7:0] d, input logic [7:0] s);
        logic [7:0] nd;
        logic [7:0] ns;
        nd = 8'd255 - d;
        ns = 8'd255 - s;
        return 8'd255 - scale_chan(nd, ns);
    endfunction

    function automatic logic [7:0] pct_chan(input logic [7:0] f, input logic [7:0] t,
                                            input logic [7:0] p);
        int unsigned v;
        if (t >= f)
            v = f + ((t - f) * p) / 100;
        else
            v = f - ((f - t) * p) / 100;
        return v[7:0];
    endfunction

    function automatic logic [31:0] blended_pixel(input logic [3:0] kind, input logic [31:0] d,
                                                  input logic [31:0] s, input logic [7:0] a);
        logic [7:0] dc[4];
        logic [7:0] sc[4];
        logic [7:0] rc[4];
        logic [7:0] mx;
        logic [7:0] mn;
        logic [8:0] gray;
        int         i;
        // Channel index 0 is blue, 3 is alpha.
        for (i = 0; i < 4; i++) begin
            dc[i] = d[8*i +: 8];
            sc[i] = s[8*i +: 8];
            rc[i] = 8'hff;
        end
        case (kind)
            MODE_SRC_ALPHA: begin
                for (i = 0; i < 3; i++) rc[i] = mix_chan(dc[i], sc[i], sc[3]);
            end
            MODE_BLEND: begin
                for (i = 0; i < 3; i++) rc[i] = mix_chan(dc[i], sc[i], a);
            end
            MODE_INTERP: begin
                for (i = 0; i < 4; i++) rc[i] = mix_chan(dc[i], sc[i], a);
            end
            MODE_DARKEN: begin
                for (i = 0; i < 3; i++) rc[i] = scale_chan(dc[i], a);
            end
            MODE_FADE: begin
                for (i = 0; i < 4; i++) rc[i] = scale_chan(dc[i], a);
            end
            MODE_PREMULT: begin
                for (i = 0; i < 3; i++) rc[i] = scale_chan(dc[i], a);
                rc[3] = a;
            end
            MODE_SCREEN: begin
                for (i = 0; i < 3; i++) rc[i] = screen_chan(dc[i], sc[i]);
            end
            MODE_DESAT: begin
                mx = dc[0];
                mn = dc[0];
                for (i = 1; i < 3; i++) begin
                    if (dc[i] > mx) mx = dc[i];
                    if (dc[i] < mn) mn = dc[i];
                end
                gray = ({1'b0, mx} + {1'b0, mn}) >> 1;
                for (i = 0; i < 3; i++) rc[i] = gray[7:0];
                rc[3] = dc[3];
            end
            MODE_PCT_FADE: begin
                if (a == 8'd0)
                    return d;
                if (a >= 8'd100)
                    return s;
                for (i = 0; i < 3; i++) rc[i] = pct_chan(dc[i], sc[i], a);
            end
            default: begin
                return 32'h0;
            end
        endcase
        return {rc[3], rc[2], rc[1], rc[0]};
    endfunction

    // Channels lean toward 0x00 and 0xff so that saturation and the
    // endpoints of the scaling come up often.
    function automatic logic [31:0] random_pixel();
        logic [31:0] p;
        int          i;
        for (i = 0; i < 4; i++) begin
            case ($urandom_range(0, 7))
                0:       p[8*i +: 8] = 8'h00;
                1:       p[8*i +: 8] = 8'hff;
                default: p[8*i +: 8] = 8'($urandom);
            endcase
        end
        return p;
    endfunction

    function automatic logic [7:0] random_amount(input logic [3:0] kind);
        case ($urandom_range(0, 9))
            0: return 8'd0;
            1: return 8'd255;
            2, 3, 4: return (kind == MODE_PCT_FADE) ? 8'($urandom_range(0, 100))
                                                     : 8'($urandom);
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [3:0] random_kind();
        if ($urandom_range(0, 99) < 5)
            return 4'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
        return 4'($urandom_range(MODE_SRC_ALPHA, MODE_PCT_FADE));
    endfunction

    // Offers one beat and holds it until the block takes it. tvalid stays
    // high afterwards so that back-to-back beats need no extra edge.
    task automatic send_pixel(input logic [3:0] kind, input logic [31:0] d,
                              input logic [31:0] s, input logic [7:0] a);
        if (tx_idle_enable && $urandom_range(0, 99) < 10) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < 30);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {a, s, d};
        s_axis_tuser  <= kind;
        do @(posedge i_clk); while (!s_axis_tready);
        expected_pixels.push_back(blended_pixel(kind, d, s, a));
    endtask

    task automatic send_random(input int count);
        logic [3:0] kind;
        repeat (count) begin
            kind = random_kind();
            send_pixel(kind, random_pixel(), random_pixel(), random_amount(kind));
        end
    endtask

    task automatic wait_until_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed_modes();
        send_pixel(MODE_SRC_ALPHA, 32'hff102030, 32'h00ffffff, 8'h55);
        send_pixel(MODE_SRC_ALPHA, 32'h12345678, 32'hff807060, 8'h00);
        send_pixel(MODE_SRC_ALPHA, 32'hffffffff, 32'h80ffffff, 8'hff);
        send_pixel(MODE_BLEND,     32'h11223344, 32'hccddeeff, 8'd0);
        send_pixel(MODE_BLEND,     32'h11223344, 32'hccddeeff, 8'd255);
        send_pixel(MODE_BLEND,     32'hffffffff, 32'hffffffff, 8'd128);
        send_pixel(MODE_INTERP,    32'h40506070, 32'hc0b0a090, 8'd0);
        send_pixel(MODE_INTERP,    32'h40506070, 32'hc0b0a090, 8'd255);
        send_pixel(MODE_INTERP,    32'h00000000, 32'hffffffff, 8'd127);
        send_pixel(MODE_DARKEN,    32'h7f8090a0, 32'hffffffff, 8'd0);
        send_pixel(MODE_DARKEN,    32'hffffffff, 32'h00000000, 8'd255);
        send_pixel(MODE_FADE,      32'hffffffff, 32'h00000000, 8'd128);
        send_pixel(MODE_FADE,      32'hffffffff, 32'hffffffff, 8'd0);
        // Premultiply by zero clears the alpha as well.
        send_pixel(MODE_PREMULT,   32'hffffffff, 32'hffffffff, 8'd0);
        send_pixel(MODE_PREMULT,   32'h80ff7f01, 32'h00000000, 8'd255);
        send_pixel(MODE_PREMULT,   32'hffffffff, 32'h00000000, 8'd1);
        send_pixel(MODE_SCREEN,    32'h00000000, 32'h00000000, 8'd0);
        send_pixel(MODE_SCREEN,    32'hffffffff, 32'hffffffff, 8'd255);
        send_pixel(MODE_SCREEN,    32'h12408080, 32'h34c04020, 8'd77);
        send_pixel(MODE_DESAT,     32'h7fff0010, 32'h00000000, 8'd0);
        send_pixel(MODE_DESAT,     32'hff00ffff, 32'hffffffff, 8'd255);
        // Percent fade: both endpoints, an amount above the clamp, and between.
        send_pixel(MODE_PCT_FADE,  32'h1020a0f0, 32'hf0e01000, 8'd0);
        send_pixel(MODE_PCT_FADE,  32'h1020a0f0, 32'h70e01000, 8'd100);
        send_pixel(MODE_PCT_FADE,  32'h1020a0f0, 32'h70e01000, 8'd255);
        send_pixel(MODE_PCT_FADE,  32'h00ff0080, 32'hff00ff7f, 8'd50);
        send_pixel(MODE_PCT_FADE,  32'h00ff00ff, 32'hff00ff00, 8'd99);
        send_pixel(MODE_UNUSED_LO, 32'hffffffff, 32'hffffffff, 8'd255);
        send_pixel(MODE_UNUSED_HI, 32'hffffffff, 32'hffffffff, 8'd255);
    endtask

    task automatic test_random_traffic();
        send_random(260);
    endtask

    task automatic test_back_to_back();
        tx_idle_enable = 1'b0;
        rx_idle_enable = 1'b0;
        send_random(60);
        tx_idle_enable = 1'b1;
        rx_idle_enable = 1'b1;
    endtask

    // The receiver stops for a long stretch while beats keep coming, so the
    // pipeline fills and the input side has to stall.
    task automatic test_output_backpressure();
        hold_requests++;
        send_random(40);
    endtask

    task automatic test_pause_until_empty();
        send_random(8);
        wait_until_drained();
        send_random(8);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if (hold_served != hold_requests) begin
            m_axis_tready <= 1'b0;
            hold_left     <= HoldCycles - 1;
            hold_served   <= hold_served + 1;
        end else if (!rx_idle_enable) begin
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= 10);
        end
    end

    always @(posedge i_clk) begin
        logic [31:0] want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_pixels.size() == 0) begin
                if (fail_count < MaxReported)
                    $display("unexpected result beat: result_pixel=%08h", m_axis_tdata);
                fail_count++;
            end else begin
                want = expected_pixels.pop_front();
                if (m_axis_tdata !== want) begin
                    if (fail_count < MaxReported)
                        $display("result_pixel mismatch: expected %08h, got %08h",
                                 want, m_axis_tdata);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= StallLimit) begin
            $display("argb_pixel_blend_unit_test NOT OK");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_modes();
        test_random_traffic();
        test_back_to_back();
        test_output_backpressure();
        test_pause_until_empty();
        wait_until_drained();
        repeat (DrainCycles) @(posedge i_clk);
        if (fail_count == 0 && expected_pixels.size() == 0)
            $display("argb_pixel_blend_unit_test OK");
        else
            $display("argb_pixel_blend_unit_test NOT OK");
        $finish;
    end

endmodule

// ===== argb_pixel_blend_unit.f =====
hdl/apbu_pkg.sv
hdl/apbu_lane.sv
hdl/argb_pixel_blend_unit.sv
bench/argb_pixel_blend_unit_test.sv
